/* rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define SDF_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be seen
`define SDF_NEVER(label, clk, rst_n, cond, msg) \
	`SDF_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

/* rtl/sdf_pkg.sv */
package sdf_pkg;

	localparam int DIM_BITS_DEF = 14;
	localparam int MODE_BITS    = 3;
	localparam int ST_BITS      = 2;
	// x100 needs seven more bits than the operand
	localparam int RATIO_EXTRA  = 7;
	localparam int HUNDREDTHS   = 100;
	localparam int LANES        = 3;

	// divider lanes
	localparam int LANE_FIT = 0;
	localparam int LANE_RS  = 1;
	localparam int LANE_RA  = 2;

	localparam logic [MODE_BITS-1:0] MODE_IDENTITY = 3'd0;
	localparam logic [MODE_BITS-1:0] MODE_CENTER   = 3'd1;
	localparam logic [MODE_BITS-1:0] MODE_FULL     = 3'd2;
	localparam logic [MODE_BITS-1:0] MODE_ASPECT   = 3'd3;

	localparam logic [ST_BITS-1:0] ST_OK       = 2'd0;
	localparam logic [ST_BITS-1:0] ST_BAD_MODE = 2'd1;
	localparam logic [ST_BITS-1:0] ST_ZERO_DIV = 2'd2;

	typedef enum logic [1:0] {
		SEL_PASS,
		SEL_PILLAR,
		SEL_RATIO
	} sel_t;

	typedef struct packed {
		sel_t                sel;
		logic                swz;
		logic [ST_BITS-1:0]  st;
	} side_t;

endpackage

/* rtl/scaler_destination_fit_unit.sv */
// channel  dir  tdata (low bit up)                                   tuser
// s_axis   in   src_width, src_height, active_width, active_height   mode
// m_axis   out  dest_width, dest_height, status                      -
//
// One beat per cycle sustained while m_tready is high; the pipeline is
// two set-up stages (products, branch pick), then DIM_BITS+7 divider cells,
// one quotient bit each, then the output register.
// Reset clears the valid bits only; no clearing pass.
// Every stage holds while the one after it is full, bubbles close up, so
// s_tready stays high while the first stage is free even if m_tvalid waits.
`include "assert_macros.svh"

module scaler_destination_fit_unit #(
	parameter int DIM_BITS = sdf_pkg::DIM_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// src_width, src_height, active_width, active_height
	input  logic [((4*DIM_BITS+7)/8)*8-1:0]       s_tdata,
	// mode
	input  logic [sdf_pkg::MODE_BITS-1:0]         s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// dest_width, dest_height, status
	output logic [((2*DIM_BITS+sdf_pkg::ST_BITS+7)/8)*8-1:0] m_tdata
);

	localparam int QB    = DIM_BITS + sdf_pkg::RATIO_EXTRA;
	localparam int OUT_W = ((2 * DIM_BITS + sdf_pkg::ST_BITS + 7) / 8) * 8;

	logic [QB:0] v_c;
	logic [QB:0] rdy_c;
	logic [sdf_pkg::LANES-1:0][DIM_BITS-1:0] rem_c  [QB+1];
	logic [sdf_pkg::LANES-1:0][QB-1:0]       num_c  [QB+1];
	logic [sdf_pkg::LANES-1:0][DIM_BITS-1:0] div_c  [QB+1];
	logic [DIM_BITS-1:0]                     dw_c   [QB+1];
	logic [DIM_BITS-1:0]                     dh_c   [QB+1];
	sdf_pkg::side_t                          side_c [QB+1];

	logic                        out_rdy;
	logic                        ov_q;
	logic [DIM_BITS-1:0]         dw_q;
	logic [DIM_BITS-1:0]         dh_q;
	logic [sdf_pkg::ST_BITS-1:0] st_q;
	logic [DIM_BITS-1:0]         dw_nx;
	logic [DIM_BITS-1:0]         dh_nx;
	logic [sdf_pkg::ST_BITS-1:0] st_nx;
	logic [QB-1:0]               q_fit;
	logic                        ratio_eq;

	sdf_prep #(
		.DIM_BITS(DIM_BITS)
	) u_prep (
		.clk          (clk),
		.arst_n       (arst_n),
		.v_in         (s_tvalid),
		.rdy          (s_tready),
		.mode         (s_tuser),
		.src_width    (s_tdata[DIM_BITS-1:0]),
		.src_height   (s_tdata[2*DIM_BITS-1:DIM_BITS]),
		.active_width (s_tdata[3*DIM_BITS-1:2*DIM_BITS]),
		.active_height(s_tdata[4*DIM_BITS-1:3*DIM_BITS]),
		.nxt_rdy      (rdy_c[0]),
		.v_out        (v_c[0]),
		.rem_out      (rem_c[0]),
		.num_out      (num_c[0]),
		.div_out      (div_c[0]),
		.dw_out       (dw_c[0]),
		.dh_out       (dh_c[0]),
		.side_out     (side_c[0])
	);

	for (genvar k = 0; k < QB; k++) begin : g_cell
		sdf_cell #(
			.DIM_BITS(DIM_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.v_in    (v_c[k]),
			.rdy     (rdy_c[k]),
			.rem_in  (rem_c[k]),
			.num_in  (num_c[k]),
			.div_in  (div_c[k]),
			.dw_in   (dw_c[k]),
			.dh_in   (dh_c[k]),
			.side_in (side_c[k]),
			.nxt_rdy (rdy_c[k+1]),
			.v_out   (v_c[k+1]),
			.rem_out (rem_c[k+1]),
			.num_out (num_c[k+1]),
			.div_out (div_c[k+1]),
			.dw_out  (dw_c[k+1]),
			.dh_out  (dh_c[k+1]),
			.side_out(side_c[k+1])
		);
	end

	assign out_rdy   = !ov_q || m_tready;
	assign rdy_c[QB] = out_rdy;

	assign q_fit    = num_c[QB][sdf_pkg::LANE_FIT];
	// hundredths of both ratios
	assign ratio_eq = num_c[QB][sdf_pkg::LANE_RS] == num_c[QB][sdf_pkg::LANE_RA];

	always_comb begin
		dw_nx = dw_c[QB];
		dh_nx = dh_c[QB];
		st_nx = side_c[QB].st;
		case (side_c[QB].sel)
			sdf_pkg::SEL_PASS: begin
				st_nx = side_c[QB].st;
			end
			sdf_pkg::SEL_PILLAR: begin
				dw_nx = q_fit[DIM_BITS-1:0];
			end
			sdf_pkg::SEL_RATIO: begin
				if (ratio_eq) begin
					st_nx = sdf_pkg::ST_OK;
				end else if (side_c[QB].swz) begin
					st_nx = sdf_pkg::ST_ZERO_DIV;
				end else begin
					dh_nx = q_fit[DIM_BITS-1:0];
				end
			end
			default: begin
				st_nx = side_c[QB].st;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (out_rdy) begin
			ov_q <= v_c[QB];
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy && v_c[QB]) begin
			dw_q <= dw_nx;
			dh_q <= dh_nx;
			st_q <= st_nx;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = OUT_W'({st_q, dh_q, dw_q});

	// fitted width stays inside the timing width
	`SDF_ASSERT(a_pillar_bound, clk, arst_n,
		v_c[QB] && side_c[QB].sel == sdf_pkg::SEL_PILLAR |-> q_fit <= QB'(dw_c[QB]),
		"pillarbox width above active width")
	// letterbox height stays inside the timing height
	`SDF_ASSERT(a_lbox_bound, clk, arst_n,
		v_c[QB] && side_c[QB].sel == sdf_pkg::SEL_RATIO && !ratio_eq && !side_c[QB].swz
			|-> q_fit <= QB'(dh_c[QB]),
		"letterbox height above active height")
	`SDF_NEVER(a_status_code, clk, arst_n,
		ov_q && st_q != sdf_pkg::ST_OK && st_q != sdf_pkg::ST_BAD_MODE
			&& st_q != sdf_pkg::ST_ZERO_DIV,
		"undefined status code")

endmodule

/* rtl/sdf_prep.sv */
module sdf_prep #(
	parameter int DIM_BITS = sdf_pkg::DIM_BITS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        v_in,
	output logic                                        rdy,
	input  logic [sdf_pkg::MODE_BITS-1:0]               mode,
	input  logic [DIM_BITS-1:0]                         src_width,
	input  logic [DIM_BITS-1:0]                         src_height,
	input  logic [DIM_BITS-1:0]                         active_width,
	input  logic [DIM_BITS-1:0]                         active_height,
	input  logic                                        nxt_rdy,
	output logic                                        v_out,
	output logic [sdf_pkg::LANES-1:0][DIM_BITS-1:0]     rem_out,
	output logic [sdf_pkg::LANES-1:0][DIM_BITS+sdf_pkg::RATIO_EXTRA-1:0] num_out,
	output logic [sdf_pkg::LANES-1:0][DIM_BITS-1:0]     div_out,
	output logic [DIM_BITS-1:0]                         dw_out,
	output logic [DIM_BITS-1:0]                         dh_out,
	output sdf_pkg::side_t                              side_out
);

	localparam int QB = DIM_BITS + sdf_pkg::RATIO_EXTRA;
	localparam int PW = 2 * DIM_BITS;

	logic                          v_s1;
	logic                          v_s2;
	logic                          rdy2;
	logic [sdf_pkg::MODE_BITS-1:0] mode_s1;
	logic [DIM_BITS-1:0]           sw_s1;
	logic [DIM_BITS-1:0]           sh_s1;
	logic [DIM_BITS-1:0]           aw_s1;
	logic [DIM_BITS-1:0]           ah_s1;
	logic [PW-1:0]                 p1_s1;
	logic [PW-1:0]                 p2_s1;
	logic [QB-1:0]                 rw_s1;
	logic [QB-1:0]                 ra_s1;

	logic                          pill;
	logic                          zdiv;
	logic [PW-1:0]                 fit_num;
	logic [DIM_BITS-1:0]           fit_div;
	logic [DIM_BITS-1:0]           dw_nx;
	logic [DIM_BITS-1:0]           dh_nx;
	sdf_pkg::side_t                side_nx;

	logic [sdf_pkg::LANES-1:0][DIM_BITS-1:0] rem_s2;
	logic [sdf_pkg::LANES-1:0][QB-1:0]       num_s2;
	logic [sdf_pkg::LANES-1:0][DIM_BITS-1:0] div_s2;
	logic [DIM_BITS-1:0]                     dw_s2;
	logic [DIM_BITS-1:0]                     dh_s2;
	sdf_pkg::side_t                          side_s2;

	assign rdy2 = !v_s2 || nxt_rdy;
	assign rdy  = !v_s1 || rdy2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy) begin
			v_s1 <= v_in;
		end
	end

	// products and x100 numerators
	always_ff @(posedge clk) begin
		if (rdy && v_in) begin
			mode_s1 <= mode;
			sw_s1   <= src_width;
			sh_s1   <= src_height;
			aw_s1   <= active_width;
			ah_s1   <= active_height;
			p1_s1   <= PW'(src_width) * PW'(active_height);
			p2_s1   <= PW'(active_width) * PW'(src_height);
			rw_s1   <= QB'(src_width) * QB'(sdf_pkg::HUNDREDTHS);
			ra_s1   <= QB'(active_width) * QB'(sdf_pkg::HUNDREDTHS);
		end
	end

	always_comb begin
		pill    = p1_s1 < p2_s1;
		zdiv    = (sh_s1 == '0) || (ah_s1 == '0);
		// pillarbox divides sw*ah by sh, letterbox divides aw*sh by sw
		fit_num = pill ? p1_s1 : p2_s1;
		fit_div = pill ? sh_s1 : sw_s1;

		dw_nx       = aw_s1;
		dh_nx       = ah_s1;
		side_nx.sel = sdf_pkg::SEL_PASS;
		side_nx.swz = (sw_s1 == '0);
		side_nx.st  = sdf_pkg::ST_OK;
		case (mode_s1)
			sdf_pkg::MODE_IDENTITY, sdf_pkg::MODE_CENTER: begin
				dw_nx = sw_s1;
				dh_nx = sh_s1;
			end
			sdf_pkg::MODE_FULL: begin
				side_nx.sel = sdf_pkg::SEL_PASS;
			end
			sdf_pkg::MODE_ASPECT: begin
				if (pill) begin
					side_nx.sel = sdf_pkg::SEL_PILLAR;
				end else if (zdiv) begin
					side_nx.st = sdf_pkg::ST_ZERO_DIV;
				end else begin
					side_nx.sel = sdf_pkg::SEL_RATIO;
				end
			end
			default: begin
				side_nx.st = sdf_pkg::ST_BAD_MODE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	// quotient is known to fit in QB bits, so the top of the product
	// preloads the remainder
	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			rem_s2[sdf_pkg::LANE_FIT] <= DIM_BITS'(fit_num >> QB);
			num_s2[sdf_pkg::LANE_FIT] <= fit_num[QB-1:0];
			div_s2[sdf_pkg::LANE_FIT] <= fit_div;
			rem_s2[sdf_pkg::LANE_RS]  <= '0;
			num_s2[sdf_pkg::LANE_RS]  <= rw_s1;
			div_s2[sdf_pkg::LANE_RS]  <= sh_s1;
			rem_s2[sdf_pkg::LANE_RA]  <= '0;
			num_s2[sdf_pkg::LANE_RA]  <= ra_s1;
			div_s2[sdf_pkg::LANE_RA]  <= ah_s1;
			dw_s2                     <= dw_nx;
			dh_s2                     <= dh_nx;
			side_s2                   <= side_nx;
		end
	end

	assign v_out    = v_s2;
	assign rem_out  = rem_s2;
	assign num_out  = num_s2;
	assign div_out  = div_s2;
	assign dw_out   = dw_s2;
	assign dh_out   = dh_s2;
	assign side_out = side_s2;

endmodule

/* rtl/sdf_cell.sv */
module sdf_cell #(
	parameter int DIM_BITS = sdf_pkg::DIM_BITS_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        v_in,
	output logic                                        rdy,
	input  logic [sdf_pkg::LANES-1:0][DIM_BITS-1:0]     rem_in,
	input  logic [sdf_pkg::LANES-1:0][DIM_BITS+sdf_pkg::RATIO_EXTRA-1:0] num_in,
	input  logic [sdf_pkg::LANES-1:0][DIM_BITS-1:0]     div_in,
	input  logic [DIM_BITS-1:0]                         dw_in,
	input  logic [DIM_BITS-1:0]                         dh_in,
	input  sdf_pkg::side_t                              side_in,
	input  logic                                        nxt_rdy,
	output logic                                        v_out,
	output logic [sdf_pkg::LANES-1:0][DIM_BITS-1:0]     rem_out,
	output logic [sdf_pkg::LANES-1:0][DIM_BITS+sdf_pkg::RATIO_EXTRA-1:0] num_out,
	output logic [sdf_pkg::LANES-1:0][DIM_BITS-1:0]     div_out,
	output logic [DIM_BITS-1:0]                         dw_out,
	output logic [DIM_BITS-1:0]                         dh_out,
	output sdf_pkg::side_t                              side_out
);

	localparam int QB = DIM_BITS + sdf_pkg::RATIO_EXTRA;

	logic [sdf_pkg::LANES-1:0][DIM_BITS:0]   trial;
	logic [sdf_pkg::LANES-1:0][DIM_BITS:0]   diff;
	logic [sdf_pkg::LANES-1:0]               ge;
	logic [sdf_pkg::LANES-1:0][DIM_BITS-1:0] rem_nx;
	logic [sdf_pkg::LANES-1:0][QB-1:0]       num_nx;

	logic                                    v_q;
	logic [sdf_pkg::LANES-1:0][DIM_BITS-1:0] rem_q;
	logic [sdf_pkg::LANES-1:0][QB-1:0]       num_q;
	logic [sdf_pkg::LANES-1:0][DIM_BITS-1:0] div_q;
	logic [DIM_BITS-1:0]                     dw_q;
	logic [DIM_BITS-1:0]                     dh_q;
	sdf_pkg::side_t                          side_q;

	// one restoring step per lane; quotient bits shift in where the
	// numerator bits leave
	always_comb begin
		for (int l = 0; l < sdf_pkg::LANES; l++) begin
			trial[l]  = {rem_in[l], num_in[l][QB-1]};
			diff[l]   = trial[l] - {1'b0, div_in[l]};
			ge[l]     = trial[l] >= {1'b0, div_in[l]};
			rem_nx[l] = ge[l] ? diff[l][DIM_BITS-1:0] : trial[l][DIM_BITS-1:0];
			num_nx[l] = {num_in[l][QB-2:0], ge[l]};
		end
	end

	assign rdy = !v_q || nxt_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (rdy) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy && v_in) begin
			rem_q  <= rem_nx;
			num_q  <= num_nx;
			div_q  <= div_in;
			dw_q   <= dw_in;
			dh_q   <= dh_in;
			side_q <= side_in;
		end
	end

	assign v_out    = v_q;
	assign rem_out  = rem_q;
	assign num_out  = num_q;
	assign div_out  = div_q;
	assign dw_out   = dw_q;
	assign dh_out   = dh_q;
	assign side_out = side_q;

endmodule
